[design/prpe_pkg.sv]
// Shared types and constants for the point rotate and perspective engine.
// No dependencies; every other design file imports this package.
package prpe_pkg;

   // Item command codes
   typedef enum logic [1:0] {
      CMD_LOAD    = 2'd0,
      CMD_ROT_X   = 2'd1,
      CMD_ROT_Y   = 2'd2,
      CMD_PROJECT = 2'd3
   } cmd_type;

   // Control register indexes
   localparam logic [2:0] CSR_EYE_DISTANCE = 3'd0;
   localparam logic [2:0] CSR_SCALE_X      = 3'd1;
   localparam logic [2:0] CSR_SCALE_Y      = 3'd2;
   localparam logic [2:0] CSR_OFFSET_X     = 3'd3;
   localparam logic [2:0] CSR_OFFSET_Y     = 3'd4;
   localparam logic [2:0] CSR_POINT_COUNT  = 3'd5;

   // Top level sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_PRJ_READ,
      ST_PRJ_X,
      ST_PRJ_Y,
      ST_POST
   } ctrl_state_type;

   // Projection unit states
   typedef enum logic [1:0] {
      PU_IDLE,
      PU_MUL,
      PU_DIV,
      PU_FIN
   } proj_state_type;

   // Per-coordinate write enables of the point store
   typedef struct packed {
      logic x;
      logic y;
      logic z;
   } lane_en_type;

endpackage

[design/prpe_store.sv]
// Point store: three coordinate memories sharing one write and one read address.
// Depends on prpe_pkg for the lane write enable struct.
module prpe_store #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  prpe_pkg::lane_en_type     wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic signed [WIDTH-1:0]   wr_x,
   input  logic signed [WIDTH-1:0]   wr_y,
   input  logic signed [WIDTH-1:0]   wr_z,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic signed [WIDTH-1:0]   rd_x,
   output logic signed [WIDTH-1:0]   rd_y,
   output logic signed [WIDTH-1:0]   rd_z
);
   import prpe_pkg::*;

   logic [WIDTH-1:0] mem_x [DEPTH];
   logic [WIDTH-1:0] mem_y [DEPTH];
   logic [WIDTH-1:0] mem_z [DEPTH];
   logic [WIDTH-1:0] rd_x_ff;
   logic [WIDTH-1:0] rd_y_ff;
   logic [WIDTH-1:0] rd_z_ff;

   // Write each coordinate lane on its own enable
   always_ff @(posedge clock) begin
      if (wr_en.x) begin
         mem_x[wr_addr] <= wr_x;
      end
      if (wr_en.y) begin
         mem_y[wr_addr] <= wr_y;
      end
      if (wr_en.z) begin
         mem_z[wr_addr] <= wr_z;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_x_ff <= mem_x[rd_addr];
         rd_y_ff <= mem_y[rd_addr];
         rd_z_ff <= mem_z[rd_addr];
      end
   end

   assign rd_x = $signed(rd_x_ff);
   assign rd_y = $signed(rd_y_ff);
   assign rd_z = $signed(rd_z_ff);

endmodule

[design/prpe_rot.sv]
// Rotation datapath: registered products, then rounding and saturation.
// Depends on prpe_pkg; fed from the point store read port.
module prpe_rot #(
   parameter int COORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           in_valid,
   input  logic                           rot_x,
   input  logic signed [COORD_BITS-1:0]   u,
   input  logic signed [COORD_BITS-1:0]   w,
   input  logic signed [15:0]             sin_v,
   input  logic signed [15:0]             cos_v,
   output logic signed [COORD_BITS-1:0]   u_new,
   output logic signed [COORD_BITS-1:0]   w_new
);
   import prpe_pkg::*;

   localparam int PW = COORD_BITS + 16;
   localparam int SW = COORD_BITS + 18;
   localparam int RW = SW - 14;
   localparam logic signed [SW-1:0] HALF = SW'(8192);
   localparam logic signed [RW-1:0] CMAX = {{(RW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [RW-1:0] CMIN = {{(RW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

   logic signed [PW-1:0] p_uc_ff;
   logic signed [PW-1:0] p_ws_ff;
   logic signed [PW-1:0] p_wc_ff;
   logic signed [PW-1:0] p_us_ff;
   logic signed [SW-1:0] sum_u;
   logic signed [SW-1:0] sum_w;
   logic signed [RW-1:0] rnd_u;
   logic signed [RW-1:0] rnd_w;

   function automatic logic signed [COORD_BITS-1:0] sat_c(input logic signed [RW-1:0] v);
      logic signed [COORD_BITS-1:0] r;
      begin
         if (v > CMAX) begin
            r = CMAX[COORD_BITS-1:0];
         end else if (v < CMIN) begin
            r = CMIN[COORD_BITS-1:0];
         end else begin
            r = v[COORD_BITS-1:0];
         end
         return r;
      end
   endfunction

   // Register the four products of the point being rotated
   always_ff @(posedge clock) begin
      if (in_valid) begin
         p_uc_ff <= PW'(u) * PW'(cos_v);
         p_ws_ff <= PW'(w) * PW'(sin_v);
         p_wc_ff <= PW'(w) * PW'(cos_v);
         p_us_ff <= PW'(u) * PW'(sin_v);
      end
   end

   // Combine with the sign of the axis, round to nearest and saturate
   always_comb begin
      if (rot_x) begin
         sum_u = SW'(p_uc_ff) + SW'(p_ws_ff) + HALF;
         sum_w = SW'(p_wc_ff) - SW'(p_us_ff) + HALF;
      end else begin
         sum_u = SW'(p_uc_ff) - SW'(p_ws_ff) + HALF;
         sum_w = SW'(p_wc_ff) + SW'(p_us_ff) + HALF;
      end
      rnd_u = $signed(sum_u[SW-1:14]);
      rnd_w = $signed(sum_w[SW-1:14]);
   end

   assign u_new = sat_c(rnd_u);
   assign w_new = sat_c(rnd_w);

endmodule

[design/prpe_proj.sv]
// Projection unit: scale*coord by shift-add, restoring divide by eye+z,
// then offset and saturation. Depends on prpe_pkg for its state type.
module prpe_proj #(
   parameter int COORD_BITS = 32
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              start,
   input  logic                                              behind,
   input  logic signed [31:0]                                scale,
   input  logic signed [COORD_BITS-1:0]                      coord,
   input  logic [((COORD_BITS > 32) ? COORD_BITS : 32)-1:0]  divisor,
   input  logic signed [31:0]                                offset,
   output logic                                              done,
   output logic signed [31:0]                                result
);
   import prpe_pkg::*;

   localparam int D_W    = (COORD_BITS > 32) ? COORD_BITS : 32;
   localparam int PROD_W = COORD_BITS + 31;
   localparam int CNT_W  = $clog2(PROD_W);
   localparam int QS_W   = 43;
   localparam logic [PROD_W-1:0] QLIM = {{(PROD_W-41){1'b0}}, 1'b1, 40'b0};
   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   proj_state_type          state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [31:0]             a_ff, a_in;
   logic [COORD_BITS-1:0]   b_ff, b_in;
   logic                    neg_ff, neg_in;
   logic [D_W-1:0]          ud_ff, ud_in;
   logic signed [31:0]      off_ff, off_in;
   logic [PROD_W-1:0]       acc_ff, acc_in;
   logic [D_W-1:0]          r_ff, r_in;
   logic                    done_ff, done_in;
   logic signed [31:0]      res_ff, res_in;
   logic [D_W:0]            rs;
   logic                    ge;
   logic signed [QS_W-1:0]  qs;
   logic signed [QS_W-1:0]  qsum;
   logic                    start_neg;

   function automatic logic signed [31:0] sat32(input logic signed [QS_W-1:0] v);
      logic signed [31:0] r;
      begin
         if (v > QS_W'(S32_MAX)) begin
            r = S32_MAX;
         end else if (v < QS_W'(S32_MIN)) begin
            r = S32_MIN;
         end else begin
            r = v[31:0];
         end
         return r;
      end
   endfunction

   assign start_neg = scale[31] ^ coord[COORD_BITS-1];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PU_IDLE: begin
            if (start && !behind) begin
               state_in = PU_MUL;
            end
         end
         PU_MUL: begin
            if (cnt_ff == '0) begin
               state_in = PU_DIV;
            end
         end
         PU_DIV: begin
            if (cnt_ff == '0) begin
               state_in = PU_FIN;
            end
         end
         PU_FIN: begin
            state_in = PU_IDLE;
         end
         default: begin
            state_in = PU_IDLE;
         end
      endcase
   end

   // Datapath
   always_comb begin
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      neg_in  = neg_ff;
      ud_in   = ud_ff;
      off_in  = off_ff;
      acc_in  = acc_ff;
      r_in    = r_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      rs      = {r_ff, acc_ff[PROD_W-1]};
      ge      = rs >= {1'b0, ud_ff};
      qs      = neg_ff ? -QS_W'({1'b0, acc_ff[41:0]}) : QS_W'({1'b0, acc_ff[41:0]});
      qsum    = qs + QS_W'(off_ff);
      unique case (state_ff)
         PU_IDLE: begin
            // Latch operands; the behind-eye case resolves at once
            if (start) begin
               a_in   = scale[31] ? 32'(-scale) : 32'(scale);
               b_in   = coord[COORD_BITS-1] ? COORD_BITS'(-coord) : COORD_BITS'(coord);
               neg_in = start_neg;
               ud_in  = divisor;
               off_in = offset;
               acc_in = '0;
               cnt_in = CNT_W'(COORD_BITS - 1);
               if (behind) begin
                  done_in = 1'b1;
                  if (scale == '0 || coord == '0) begin
                     res_in = offset;
                  end else begin
                     res_in = start_neg ? S32_MIN : S32_MAX;
                  end
               end
            end
         end
         PU_MUL: begin
            // One multiplier bit a cycle, most significant first
            acc_in = {acc_ff[PROD_W-2:0], 1'b0} + (b_ff[COORD_BITS-1] ? PROD_W'(a_ff) : '0);
            b_in   = {b_ff[COORD_BITS-2:0], 1'b0};
            r_in   = '0;
            cnt_in = (cnt_ff == '0) ? CNT_W'(PROD_W - 1) : cnt_ff - 1'b1;
         end
         PU_DIV: begin
            // One quotient bit a cycle; dividend shifts out as quotient shifts in
            r_in   = ge ? D_W'(rs - {1'b0, ud_ff}) : rs[D_W-1:0];
            acc_in = {acc_ff[PROD_W-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
         end
         PU_FIN: begin
            done_in = 1'b1;
            if (acc_ff > QLIM) begin
               res_in = neg_ff ? S32_MIN : S32_MAX;
            end else begin
               res_in = sat32(qsum);
            end
         end
         default: begin
            done_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PU_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      neg_ff <= neg_in;
      ud_ff  <= ud_in;
      off_ff <= off_in;
      acc_ff <= acc_in;
      r_ff   <= r_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

[design/point_rotate_perspective_engine_unit.sv]
// Point rotate and perspective engine. Holds POINT_DEPTH points in a store of
// three synchronous memories. A load transaction writes the store on accept.
// A rotation sweeps points 0 to point_count-1 (at most POINT_DEPTH) through a
// read, multiply, write-back pipeline on the store's single read and write
// ports, holding the input off until the last point is written back.
// A project transaction reads one point, then runs x and y in turn through one
// shared shift-add multiplier and restoring divider, one bit a cycle; a point
// behind the eye skips the multiply and divide. The result register lets the
// next transaction in while a result waits.
// Store contents are undefined after reset until loaded; there is no clear.
// Depends on prpe_pkg, prpe_store, prpe_rot and prpe_proj.
module point_rotate_perspective_engine_unit #(
   parameter int POINT_DEPTH = 1024,
   parameter int COORD_BITS  = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [9:0]          req_point_index,
   input  logic signed [31:0]  req_coord_x,
   input  logic signed [31:0]  req_coord_y,
   input  logic signed [31:0]  req_coord_z,
   input  logic signed [15:0]  req_rot_sin,
   input  logic signed [15:0]  req_rot_cos,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [9:0]          rsp_result_index,
   output logic signed [31:0]  rsp_screen_x,
   output logic signed [31:0]  rsp_screen_y,
   output logic                rsp_behind_eye
);
   import prpe_pkg::*;

   localparam int AW   = $clog2(POINT_DEPTH);
   localparam int NW   = $clog2(POINT_DEPTH + 1);
   localparam int D_W  = (COORD_BITS > 32) ? COORD_BITS : 32;
   localparam int DS_W = D_W + 1;
   localparam int LW   = COORD_BITS + 33;
   localparam logic signed [LW-1:0] CMAX = {{(LW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [LW-1:0] CMIN = {{(LW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

   ctrl_state_type               state_ff, state_in;
   logic [30:0]                  eye_ff;
   logic signed [31:0]           scale_x_ff, scale_y_ff, offset_x_ff, offset_y_ff;
   logic [10:0]                  pcount_ff;
   cmd_type                      cmd_ff;
   logic [9:0]                   idx_ff;
   logic                         inrange_ff;
   logic signed [15:0]           sin_ff, cos_ff;
   logic [NW-1:0]                n_ff, rd_cnt_ff;
   logic                         v1_ff, v2_ff;
   logic [AW-1:0]                a1_ff, a2_ff;
   logic signed [COORD_BITS-1:0] y_ff;
   logic [D_W-1:0]               d_ff;
   logic                         behind_ff;
   logic signed [31:0]           px_ff;
   logic                         rsp_valid_ff;
   logic [9:0]                   rsp_index_ff;
   logic signed [31:0]           rsp_x_ff, rsp_y_ff;
   logic                         rsp_behind_ff;

   cmd_type                      req_cmd_t;
   logic                         req_acc;
   logic                         req_inrange;
   logic [17:0]                  pc_lim;
   logic                         rot_x;
   logic                         sweep_rd;
   logic                         sweep_done;
   logic                         rsp_load;
   lane_en_type                  mem_we;
   logic [AW-1:0]                mem_waddr, mem_raddr;
   logic signed [COORD_BITS-1:0] mem_wx, mem_wy, mem_wz;
   logic                         mem_re;
   logic signed [COORD_BITS-1:0] rd_x, rd_y, rd_z;
   logic signed [COORD_BITS-1:0] u_new, w_new;
   logic signed [COORD_BITS-1:0] x_live, y_live, z_live;
   logic signed [DS_W-1:0]       dsum;
   logic                         behind_live;
   logic                         pu_start, pu_behind, pu_done;
   logic signed [31:0]           pu_scale, pu_offset, pu_result;
   logic signed [COORD_BITS-1:0] pu_coord;
   logic [D_W-1:0]               pu_div;

   function automatic logic signed [COORD_BITS-1:0] sat_load(input logic signed [31:0] v);
      logic signed [LW-1:0] e;
      logic signed [COORD_BITS-1:0] r;
      begin
         e = LW'(v);
         if (e > CMAX) begin
            r = CMAX[COORD_BITS-1:0];
         end else if (e < CMIN) begin
            r = CMIN[COORD_BITS-1:0];
         end else begin
            r = e[COORD_BITS-1:0];
         end
         return r;
      end
   endfunction

   assign req_cmd_t   = cmd_type'(req_cmd);
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_acc     = req_valid && !req_stall;
   assign req_inrange = 18'(req_point_index) < 18'(POINT_DEPTH);
   assign pc_lim      = (18'(pcount_ff) > 18'(POINT_DEPTH)) ? 18'(POINT_DEPTH) : 18'(pcount_ff);
   assign rot_x       = (cmd_ff == CMD_ROT_X);
   assign sweep_rd    = (state_ff == ST_SWEEP) && (rd_cnt_ff != n_ff);
   assign sweep_done  = (state_ff == ST_SWEEP) && (rd_cnt_ff == n_ff) && !v1_ff && !v2_ff;
   assign rsp_load    = (state_ff == ST_POST) && (!rsp_valid_ff || !rsp_stall);

   // Projected point, with an out-of-range index reading as the origin
   assign x_live      = inrange_ff ? rd_x : '0;
   assign y_live      = inrange_ff ? rd_y : '0;
   assign z_live      = inrange_ff ? rd_z : '0;
   assign dsum        = DS_W'({1'b0, eye_ff}) + DS_W'(z_live);
   assign behind_live = dsum[DS_W-1] || (dsum == '0);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               unique case (req_cmd_t)
                  CMD_ROT_X, CMD_ROT_Y: state_in = ST_SWEEP;
                  CMD_PROJECT:          state_in = ST_PRJ_READ;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_SWEEP: begin
            if (sweep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_PRJ_READ: begin
            state_in = ST_PRJ_X;
         end
         ST_PRJ_X: begin
            if (pu_done) begin
               state_in = ST_PRJ_Y;
            end
         end
         ST_PRJ_Y: begin
            if (pu_done) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Store ports and projection unit controls
   always_comb begin
      mem_we    = '0;
      mem_waddr = a2_ff;
      mem_wx    = u_new;
      mem_wy    = u_new;
      mem_wz    = w_new;
      mem_re    = 1'b0;
      mem_raddr = rd_cnt_ff[AW-1:0];
      pu_start  = 1'b0;
      pu_behind = behind_ff;
      pu_scale  = scale_y_ff;
      pu_offset = offset_y_ff;
      pu_coord  = y_ff;
      pu_div    = d_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_cmd_t == CMD_LOAD && req_inrange) begin
               mem_we    = '{x: 1'b1, y: 1'b1, z: 1'b1};
               mem_waddr = AW'(req_point_index);
               mem_wx    = sat_load(req_coord_x);
               mem_wy    = sat_load(req_coord_y);
               mem_wz    = sat_load(req_coord_z);
            end
            if (req_acc && req_cmd_t == CMD_PROJECT) begin
               mem_re    = 1'b1;
               mem_raddr = AW'(req_point_index);
            end
         end
         ST_SWEEP: begin
            mem_re = sweep_rd;
            if (v2_ff) begin
               mem_we = '{x: !rot_x, y: rot_x, z: 1'b1};
            end
         end
         ST_PRJ_READ: begin
            pu_start  = 1'b1;
            pu_behind = behind_live;
            pu_scale  = scale_x_ff;
            pu_offset = offset_x_ff;
            pu_coord  = x_live;
            pu_div    = dsum[D_W-1:0];
         end
         ST_PRJ_X: begin
            pu_start = pu_done;
         end
         ST_PRJ_Y, ST_POST: begin
            pu_start = 1'b0;
         end
         default: begin
            pu_start = 1'b0;
         end
      endcase
   end

   // Control registers, sequencer and pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eye_ff       <= 31'd65536;
         scale_x_ff   <= 32'sd65536;
         scale_y_ff   <= 32'sd65536;
         offset_x_ff  <= '0;
         offset_y_ff  <= '0;
         pcount_ff    <= '0;
         rd_cnt_ff    <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_EYE_DISTANCE: eye_ff      <= csr_wdata[30:0];
               CSR_SCALE_X:      scale_x_ff  <= $signed(csr_wdata);
               CSR_SCALE_Y:      scale_y_ff  <= $signed(csr_wdata);
               CSR_OFFSET_X:     offset_x_ff <= $signed(csr_wdata);
               CSR_OFFSET_Y:     offset_y_ff <= $signed(csr_wdata);
               CSR_POINT_COUNT:  pcount_ff   <= csr_wdata[10:0];
               default:          pcount_ff   <= pcount_ff;
            endcase
         end
         if (req_acc) begin
            rd_cnt_ff <= '0;
         end else if (sweep_rd) begin
            rd_cnt_ff <= rd_cnt_ff + 1'b1;
         end
         v1_ff <= sweep_rd;
         v2_ff <= v1_ff;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Transaction fields, sweep addresses and projection results
   always_ff @(posedge clock) begin
      if (req_acc) begin
         cmd_ff     <= req_cmd_t;
         idx_ff     <= req_point_index;
         inrange_ff <= req_inrange;
         sin_ff     <= req_rot_sin;
         cos_ff     <= req_rot_cos;
         n_ff       <= NW'(pc_lim);
      end
      a1_ff <= rd_cnt_ff[AW-1:0];
      a2_ff <= a1_ff;
      if (state_ff == ST_PRJ_READ) begin
         y_ff      <= y_live;
         d_ff      <= dsum[D_W-1:0];
         behind_ff <= behind_live;
      end
      if (state_ff == ST_PRJ_X && pu_done) begin
         px_ff <= pu_result;
      end
      if (rsp_load) begin
         rsp_index_ff  <= idx_ff;
         rsp_x_ff      <= px_ff;
         rsp_y_ff      <= pu_result;
         rsp_behind_ff <= behind_ff;
      end
   end

   prpe_store #(
      .DEPTH (POINT_DEPTH),
      .WIDTH (COORD_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_x    (mem_wx),
      .wr_y    (mem_wy),
      .wr_z    (mem_wz),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_x    (rd_x),
      .rd_y    (rd_y),
      .rd_z    (rd_z)
   );

   prpe_rot #(
      .COORD_BITS (COORD_BITS)
   ) u_rot (
      .clock    (clock),
      .in_valid (v1_ff),
      .rot_x    (rot_x),
      .u        (rot_x ? rd_y : rd_x),
      .w        (rd_z),
      .sin_v    (sin_ff),
      .cos_v    (cos_ff),
      .u_new    (u_new),
      .w_new    (w_new)
   );

   prpe_proj #(
      .COORD_BITS (COORD_BITS)
   ) u_proj (
      .clock   (clock),
      .reset   (reset),
      .start   (pu_start),
      .behind  (pu_behind),
      .scale   (pu_scale),
      .coord   (pu_coord),
      .divisor (pu_div),
      .offset  (pu_offset),
      .done    (pu_done),
      .result  (pu_result)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_screen_x     = rsp_x_ff;
   assign rsp_screen_y     = rsp_y_ff;
   assign rsp_behind_eye   = rsp_behind_ff;

`ifndef SYNTH
   // Write-back never lands on the entry being read in the same sweep cycle
   a_sweep_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && sweep_rd) |-> (a2_ff != rd_cnt_ff[AW-1:0]))
      else $error("sweep write-back collides with read");

   // Projection unit finishes only while an axis is awaited
   a_done_in_axis: assert property (@(posedge clock) disable iff (reset)
      pu_done |-> (state_ff == ST_PRJ_X || state_ff == ST_PRJ_Y))
      else $error("projection unit done outside an axis state");

   // A project transaction always starts with the store read
   a_project_reads: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_cmd_t == CMD_PROJECT) |=> (state_ff == ST_PRJ_READ))
      else $error("project transaction did not read the store");

   // A finished projection is posted when the result register is free
   a_post_fills: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POST && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished projection not posted");
`endif

endmodule

[dv/point_rotate_perspective_engine_unit_tb.sv]
// Self-checking testbench for point_rotate_perspective_engine_unit.
// A scoreboard class predicts every projection; tasks drive load, rotate and project.
// Depends on prpe_pkg and the engine RTL only.
`timescale 1ns / 100ps

module point_rotate_perspective_engine_unit_tb;
   import prpe_pkg::*;

   localparam int     DEPTH         = 1024;
   localparam longint S32_MAX       = 64'sd2147483647;
   localparam longint S32_MIN       = -64'sd2147483648;
   localparam int     SETTLE_CYCLES = 1100;
   localparam int     WATCHDOG_MAX  = 20000;
   localparam int     HOLD_CYCLES   = 1500;
   localparam logic [2:0] CSR_SPARE_6 = 3'd6;
   localparam logic [2:0] CSR_SPARE_7 = 3'd7;

   typedef struct {
      logic [9:0]         index;
      logic signed [31:0] sx;
      logic signed [31:0] sy;
      logic               behind;
   } projection_type;

   // Scoreboard: its own copy of the point store and the registers
   class projection_scoreboard;
      longint         store_x [DEPTH];
      longint         store_y [DEPTH];
      longint         store_z [DEPTH];
      longint         eye_dist, gain_x, gain_y, centre_x, centre_y;
      int unsigned    sweep_count;
      projection_type expected_q[$];
      int unsigned    mismatches, results_seen, behind_seen;

      function new();
         eye_dist    = 65536;
         gain_x      = 65536;
         gain_y      = 65536;
         centre_x    = 0;
         centre_y    = 0;
         sweep_count = 0;
         mismatches  = 0;
         results_seen = 0;
         behind_seen = 0;
      endfunction

      static function longint sat32(longint v);
         if (v > S32_MAX) return S32_MAX;
         if (v < S32_MIN) return S32_MIN;
         return v;
      endfunction

      // round to nearest, ties upward, of v / 2^14
      static function longint round_q14(longint v);
         return (v + 64'sd8192) >>> 14;
      endfunction

      static function longint screen_axis(longint gain, longint coord, longint d,
                                          longint centre);
         longint unsigned a, b, du, q;
         bit neg;
         neg = (gain < 0) != (coord < 0);
         a   = (gain < 0) ? -gain : gain;
         b   = (coord < 0) ? -coord : coord;
         du  = d;
         q   = (a * b) / du;
         if (q > (64'd1 << 40)) return neg ? S32_MIN : S32_MAX;
         return sat32((neg ? -longint'(q) : longint'(q)) + centre);
      endfunction

      static function longint behind_axis(longint gain, longint coord, longint centre);
         if (gain == 0 || coord == 0) return sat32(centre);
         return ((gain < 0) != (coord < 0)) ? S32_MIN : S32_MAX;
      endfunction

      function void write_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            CSR_EYE_DISTANCE: eye_dist    = longint'({33'd0, data[30:0]});
            CSR_SCALE_X:      gain_x      = longint'(signed'(data));
            CSR_SCALE_Y:      gain_y      = longint'(signed'(data));
            CSR_OFFSET_X:     centre_x    = longint'(signed'(data));
            CSR_OFFSET_Y:     centre_y    = longint'(signed'(data));
            CSR_POINT_COUNT:  sweep_count = data[10:0];
            default: ;
         endcase
      endfunction

      function void note_request(cmd_type cmd, logic [9:0] idx, logic signed [31:0] cx,
                                 logic signed [31:0] cy, logic signed [31:0] cz,
                                 logic signed [15:0] rs, logic signed [15:0] rc);
         longint         ss, cc, a, b, d;
         int unsigned    n;
         projection_type p;
         ss = rs;
         cc = rc;
         n  = (sweep_count > DEPTH) ? DEPTH : sweep_count;
         case (cmd)
            CMD_LOAD: begin
               store_x[idx] = cx;
               store_y[idx] = cy;
               store_z[idx] = cz;
            end
            CMD_ROT_X: begin
               for (int i = 0; i < n; i++) begin
                  a = store_y[i];
                  b = store_z[i];
                  store_y[i] = sat32(round_q14(a * cc + b * ss));
                  store_z[i] = sat32(round_q14(b * cc - a * ss));
               end
            end
            CMD_ROT_Y: begin
               for (int i = 0; i < n; i++) begin
                  a = store_x[i];
                  b = store_z[i];
                  store_x[i] = sat32(round_q14(a * cc - b * ss));
                  store_z[i] = sat32(round_q14(a * ss + b * cc));
               end
            end
            default: begin
               d = eye_dist + store_z[idx];
               p.index  = idx;
               p.behind = (d <= 0);
               if (p.behind) begin
                  p.sx = behind_axis(gain_x, store_x[idx], centre_x);
                  p.sy = behind_axis(gain_y, store_y[idx], centre_y);
               end else begin
                  p.sx = screen_axis(gain_x, store_x[idx], d, centre_x);
                  p.sy = screen_axis(gain_y, store_y[idx], d, centre_y);
               end
               expected_q = {expected_q, p};
            end
         endcase
      endfunction

      function void check_result(logic [9:0] idx, logic signed [31:0] sx,
                                 logic signed [31:0] sy, logic be);
         projection_type p;
         if (expected_q.size() == 0) begin
            $error("projection result for entry %0d with none pending", idx);
            mismatches++;
            return;
         end
         p = expected_q.pop_front();
         results_seen++;
         if (p.behind) behind_seen++;
         if (idx !== p.index) begin
            $error("result_index expected %0d got %0d", p.index, idx);
            mismatches++;
         end
         if (sx !== p.sx) begin
            $error("screen_x expected %0d got %0d", p.sx, sx);
            mismatches++;
         end
         if (sy !== p.sy) begin
            $error("screen_y expected %0d got %0d", p.sy, sy);
            mismatches++;
         end
         if (be !== p.behind) begin
            $error("behind_eye expected %0b got %0b", p.behind, be);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_cmd;
   logic [9:0]         req_point_index;
   logic signed [31:0] req_coord_x, req_coord_y, req_coord_z;
   logic signed [15:0] req_rot_sin, req_rot_cos;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [9:0]         rsp_result_index;
   logic signed [31:0] rsp_screen_x, rsp_screen_y;
   logic               rsp_behind_eye;

   projection_scoreboard sb = new();
   bit          written [DEPTH];
   logic [9:0]  loaded_q[$];
   bit          quiet = 0;
   bit          hold_req = 0;
   bit          hold_done = 0;
   int unsigned items_sent = 0;
   int unsigned rotations = 0;
   int unsigned idle_cycles = 0;

   point_rotate_perspective_engine_unit DUT (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_point_index(req_point_index), .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y), .req_coord_z(req_coord_z),
      .req_rot_sin(req_rot_sin), .req_rot_cos(req_rot_cos),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_result_index(rsp_result_index), .rsp_screen_x(rsp_screen_x),
      .rsp_screen_y(rsp_screen_y), .rsp_behind_eye(rsp_behind_eye)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Check each result transaction as it is taken
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_result_index, rsp_screen_x, rsp_screen_y, rsp_behind_eye);
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("FAIL point_rotate_perspective_engine_unit");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Result side: random stall bursts, one long hold-off, none near the end
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_req && !hold_done) begin
            rsp_stall = 1;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_stall = 0;
            hold_done = 1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall = 1;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_stall = 0;
         end
      end
   end

   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      @(negedge clock);
      csr_we    = 1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 0;
      sb.write_reg(idx, data);
   endtask

   // Hold until every projection is back and any sweep has finished
   task automatic settle();
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(cmd_type cmd, logic [9:0] idx, logic signed [31:0] cx,
                            logic signed [31:0] cy, logic signed [31:0] cz,
                            logic signed [15:0] rs, logic signed [15:0] rc);
      int unsigned gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_cmd         = cmd;
      req_point_index = idx;
      req_coord_x     = cx;
      req_coord_y     = cy;
      req_coord_z     = cz;
      req_rot_sin     = rs;
      req_rot_cos     = rc;
      req_valid       = 1;
      do @(posedge clock); while (req_stall);
      sb.note_request(cmd, idx, cx, cy, cz, rs, rc);
      items_sent++;
      if (cmd == CMD_ROT_X || cmd == CMD_ROT_Y) rotations++;
      if (cmd == CMD_LOAD && !written[idx]) begin
         written[idx] = 1;
         loaded_q = {loaded_q, idx};
      end
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_valid = 0;
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
         2: case ($urandom_range(0, 3))
               0: return 32'sh7FFFFFFF;
               1: return 32'sh80000000;
               2: return 0;
               default: return -1;
            endcase
         default: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      endcase
   endfunction

   function automatic logic signed [15:0] rand_trig();
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic int lowest_unwritten();
      for (int i = 0; i < DEPTH; i++)
         if (!written[i]) return i;
      return DEPTH;
   endfunction

   // One random transaction; a rotation over unloaded entries becomes a load
   task automatic random_item();
      int unsigned roll, n;
      int          hole;
      cmd_type     cmd;
      logic [9:0]  idx;
      n    = (sb.sweep_count > DEPTH) ? DEPTH : sb.sweep_count;
      hole = lowest_unwritten();
      roll = $urandom_range(0, 99);
      if (roll < 35 || loaded_q.size() == 0) cmd = CMD_LOAD;
      else if (roll < 43) cmd = CMD_ROT_X;
      else if (roll < 50) cmd = CMD_ROT_Y;
      else cmd = CMD_PROJECT;
      if ((cmd == CMD_ROT_X || cmd == CMD_ROT_Y) && hole < n) begin
         cmd = CMD_LOAD;
         idx = 10'(hole);
      end else if (cmd == CMD_LOAD)
         idx = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 63))
                                          : 10'($urandom_range(0, 1023));
      else if (cmd == CMD_PROJECT)
         idx = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
      else
         idx = 10'($urandom);
      send_item(cmd, idx, rand_coord(), rand_coord(), rand_coord(), rand_trig(), rand_trig());
   endtask

   logic [31:0] phase_cfg [0:5][0:5] = '{
      '{32'h000A0000, 32'h01000000, 32'hFF000000, 32'h00100000, 32'hFFF00000, 32'd16},
      '{32'h00000001, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'd0},
      '{32'hFFFFFFFF, 32'h00000000, 32'h00010000, 32'h00000000, 32'h12345678, 32'd7},
      '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd32},
      '{32'h00200000, 32'h00400000, 32'h00400000, 32'h0, 32'h0, 32'd48},
      '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd24}
   };

   initial begin
      reset = 1;
      csr_we = 0;
      csr_index = CSR_EYE_DISTANCE;
      csr_wdata = 0;
      req_valid = 0;
      req_cmd = CMD_LOAD;
      req_point_index = 0;
      req_coord_x = 0;
      req_coord_y = 0;
      req_coord_z = 0;
      req_rot_sin = 0;
      req_rot_cos = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // Directed: extremes, behind the eye, zero depth, zero coordinate
      send_item(CMD_LOAD, 10'd0, 32'sh00010000, 32'sh00020000, 0, 0, 0);
      send_item(CMD_LOAD, 10'd1, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0, 0);
      send_item(CMD_LOAD, 10'd1023, 32'sh80000000, 32'sh7FFFFFFF, -32'sh00010000, 0, 0);
      send_item(CMD_LOAD, 10'd2, 0, 0, 32'sh80000000, 0, 0);
      send_item(CMD_LOAD, 10'd3, 32'sh00050000, -32'sh00030000, -32'sh00008000, 0, 0);
      send_item(CMD_PROJECT, 10'd0, 0, 0, 0, 0, 0);
      send_item(CMD_PROJECT, 10'd1, 0, 0, 0, 0, 0);
      send_item(CMD_PROJECT, 10'd1023, 0, 0, 0, 0, 0);
      send_item(CMD_PROJECT, 10'd2, 0, 0, 0, 0, 0);
      send_item(CMD_PROJECT, 10'd3, 0, 0, 0, 0, 0);
      // an empty sweep leaves the store alone
      send_item(CMD_ROT_X, 10'd0, 0, 0, 0, 16'sd16384, 16'sd0);
      send_item(CMD_PROJECT, 10'd0, 0, 0, 0, 0, 0);
      end_burst();
      settle();
      write_csr(CSR_POINT_COUNT, 32'd4);

      // Directed rotations, with overflow and out-of-range sine and cosine
      send_item(CMD_ROT_X, 10'd0, 0, 0, 0, 16'sd16384, 16'sd0);
      send_item(CMD_ROT_Y, 10'd0, 0, 0, 0, -16'sd16384, 16'sd16384);
      send_item(CMD_ROT_X, 10'd0, 0, 0, 0, 16'sh7FFF, 16'sh8000);
      send_item(CMD_ROT_Y, 10'd0, 0, 0, 0, 16'sh8000, 16'sh7FFF);
      for (int i = 0; i < 4; i++)
         send_item(CMD_PROJECT, 10'(i), 0, 0, 0, 0, 0);
      end_burst();
      settle();

      // Random phases, each under a fresh register setting
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 3 || ph == 5) begin
            for (int r = 0; r < 5; r++) phase_cfg[ph][r] = $urandom;
            if (phase_cfg[ph][0][30:0] == 0) phase_cfg[ph][0] = 32'd1;
         end
         write_csr(CSR_EYE_DISTANCE, phase_cfg[ph][0]);
         write_csr(CSR_SCALE_X, phase_cfg[ph][1]);
         write_csr(CSR_SCALE_Y, phase_cfg[ph][2]);
         write_csr(CSR_OFFSET_X, phase_cfg[ph][3]);
         write_csr(CSR_OFFSET_Y, phase_cfg[ph][4]);
         write_csr(CSR_POINT_COUNT, phase_cfg[ph][5]);
         write_csr(CSR_SPARE_6, $urandom);
         write_csr(CSR_SPARE_7, $urandom);
         // a full sweep needs the whole store loaded
         if (phase_cfg[ph][5] > DEPTH)
            for (int i = 0; i < DEPTH; i++)
               if (!written[i])
                  send_item(CMD_LOAD, 10'(i), rand_coord(), rand_coord(), rand_coord(), 0, 0);
         if (ph == 1) hold_req = 1;
         for (int k = 0; k < 90; k++) begin
            if (ph == 5 && k >= 40) quiet = 1;
            random_item();
         end
         end_burst();
         settle();
      end

      $display("Sent %0d transactions, %0d rotations;", items_sent, rotations);
      $display("checked %0d projections, %0d behind the eye.",
               sb.results_seen, sb.behind_seen);
      if (sb.mismatches == 0 && sb.expected_q.size() == 0)
         $display("PASS point_rotate_perspective_engine_unit");
      else
         $display("FAIL point_rotate_perspective_engine_unit");
      $finish;
   end

endmodule
